@@ rtl/core/ps2s1_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Shared constants and character tables for the set 1 scancode translator.
// ----------------------------------------------------------------------------
package ps2s1_pkg;

  localparam int unsigned IGNORE_SLOTS_DEF = 8;
  localparam int unsigned SLOT_W           = 8;
  localparam int unsigned CODES_W          = 64;
  localparam int unsigned COUNT_W          = 4;
  localparam int unsigned APB_AW           = 4;
  localparam int unsigned APB_DW           = 64;

  // input operations
  localparam logic OP_BYTE       = 1'b0;
  localparam logic OP_SET_LAYOUT = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_SPECIAL = 2'd2;

  // scancodes
  localparam logic [7:0] SC_PREFIX    = 8'hE0;
  localparam logic [6:0] SC_LSHIFT    = 7'h2A;
  localparam logic [6:0] SC_RSHIFT    = 7'h36;
  localparam logic [6:0] SC_CTRL      = 7'h1D;
  localparam logic [6:0] SC_ALT       = 7'h38;
  localparam logic [6:0] SC_CAPS      = 7'h3A;
  localparam logic [6:0] SC_F1        = 7'h3B;
  localparam logic [6:0] SC_F10       = 7'h44;
  localparam logic [6:0] SC_LAYOUT_A  = 7'h57;
  localparam logic [6:0] SC_LAYOUT_B  = 7'h58;
  localparam logic [6:0] SC_KP_SLASH  = 7'h35;
  localparam logic [6:0] SC_E0_SLASH  = 7'h5D;

  // status bits
  localparam int unsigned ST_READY_BIT = 0;
  localparam int unsigned ST_MOUSE_BIT = 5;

  // characters
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] CTRL_LO  = 8'h60;
  localparam logic [7:0] CTRL_UP  = 8'h40;

  // navigation keys after the e0 prefix, renumbered densely
  typedef struct packed {
    logic       hit;
    logic [4:0] num;
  } nav_t;

  function automatic nav_t nav_lookup(input logic [6:0] code);
    nav_t r;
    r.hit = 1'b1;
    case (code)
      7'h48:   r.num = 5'd10;
      7'h50:   r.num = 5'd11;
      7'h4B:   r.num = 5'd12;
      7'h4D:   r.num = 5'd13;
      7'h47:   r.num = 5'd14;
      7'h4F:   r.num = 5'd15;
      7'h53:   r.num = 5'd16;
      7'h49:   r.num = 5'd17;
      7'h51:   r.num = 5'd18;
      default: begin
        r.hit = 1'b0;
        r.num = 5'd0;
      end
    endcase
    return r;
  endfunction

  // top row and keys common to both layouts, unshifted
  function automatic logic [7:0] common_lo(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h01: c = 8'h1B;
      7'h02: c = 8'h31;
      7'h03: c = 8'h32;
      7'h04: c = 8'h33;
      7'h05: c = 8'h34;
      7'h06: c = 8'h35;
      7'h07: c = 8'h36;
      7'h08: c = 8'h37;
      7'h09: c = 8'h38;
      7'h0A: c = 8'h39;
      7'h0B: c = 8'h30;
      7'h0C: c = 8'h2D;
      7'h0D: c = 8'h3D;
      7'h0E: c = 8'h08;
      7'h0F: c = 8'h09;
      7'h1C: c = 8'h0A;
      7'h2B: c = 8'h5C;
      7'h37: c = 8'h2A;
      7'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] common_up(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h01: c = 8'h1B;
      7'h02: c = 8'h21;
      7'h03: c = 8'h40;
      7'h04: c = 8'h23;
      7'h05: c = 8'h24;
      7'h06: c = 8'h25;
      7'h07: c = 8'h5E;
      7'h08: c = 8'h26;
      7'h09: c = 8'h2A;
      7'h0A: c = 8'h28;
      7'h0B: c = 8'h29;
      7'h0C: c = 8'h5F;
      7'h0D: c = 8'h2B;
      7'h0E: c = 8'h08;
      7'h0F: c = 8'h09;
      7'h1C: c = 8'h0A;
      7'h2B: c = 8'h7C;
      7'h37: c = 8'h2A;
      7'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] en_lo(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h10: c = 8'h71;
      7'h11: c = 8'h77;
      7'h12: c = 8'h65;
      7'h13: c = 8'h72;
      7'h14: c = 8'h74;
      7'h15: c = 8'h79;
      7'h16: c = 8'h75;
      7'h17: c = 8'h69;
      7'h18: c = 8'h6F;
      7'h19: c = 8'h70;
      7'h1A: c = 8'h5B;
      7'h1B: c = 8'h5D;
      7'h1E: c = 8'h61;
      7'h1F: c = 8'h73;
      7'h20: c = 8'h64;
      7'h21: c = 8'h66;
      7'h22: c = 8'h67;
      7'h23: c = 8'h68;
      7'h24: c = 8'h6A;
      7'h25: c = 8'h6B;
      7'h26: c = 8'h6C;
      7'h27: c = 8'h3B;
      7'h28: c = 8'h27;
      7'h29: c = 8'h60;
      7'h2C: c = 8'h7A;
      7'h2D: c = 8'h78;
      7'h2E: c = 8'h63;
      7'h2F: c = 8'h76;
      7'h30: c = 8'h62;
      7'h31: c = 8'h6E;
      7'h32: c = 8'h6D;
      7'h33: c = 8'h2C;
      7'h34: c = 8'h2E;
      7'h35: c = 8'h2F;
      default: c = common_lo(code);
    endcase
    return c;
  endfunction

  function automatic logic [7:0] en_up(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h10: c = 8'h51;
      7'h11: c = 8'h57;
      7'h12: c = 8'h45;
      7'h13: c = 8'h52;
      7'h14: c = 8'h54;
      7'h15: c = 8'h59;
      7'h16: c = 8'h55;
      7'h17: c = 8'h49;
      7'h18: c = 8'h4F;
      7'h19: c = 8'h50;
      7'h1A: c = 8'h7B;
      7'h1B: c = 8'h7D;
      7'h1E: c = 8'h41;
      7'h1F: c = 8'h53;
      7'h20: c = 8'h44;
      7'h21: c = 8'h46;
      7'h22: c = 8'h47;
      7'h23: c = 8'h48;
      7'h24: c = 8'h4A;
      7'h25: c = 8'h4B;
      7'h26: c = 8'h4C;
      7'h27: c = 8'h3A;
      7'h28: c = 8'h22;
      7'h29: c = 8'h7E;
      7'h2C: c = 8'h5A;
      7'h2D: c = 8'h58;
      7'h2E: c = 8'h43;
      7'h2F: c = 8'h56;
      7'h30: c = 8'h42;
      7'h31: c = 8'h4E;
      7'h32: c = 8'h4D;
      7'h33: c = 8'h3C;
      7'h34: c = 8'h3E;
      7'h35: c = 8'h3F;
      default: c = common_up(code);
    endcase
    return c;
  endfunction

  // cp866 lower case
  function automatic logic [7:0] ru_lo(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h10: c = 8'hA9;
      7'h11: c = 8'hE6;
      7'h12: c = 8'hE3;
      7'h13: c = 8'hAA;
      7'h14: c = 8'hA5;
      7'h15: c = 8'hAD;
      7'h16: c = 8'hA3;
      7'h17: c = 8'hE8;
      7'h18: c = 8'hE9;
      7'h19: c = 8'hA7;
      7'h1A: c = 8'hE5;
      7'h1B: c = 8'hEA;
      7'h1E: c = 8'hE4;
      7'h1F: c = 8'hEB;
      7'h20: c = 8'hA2;
      7'h21: c = 8'hA0;
      7'h22: c = 8'hAF;
      7'h23: c = 8'hE0;
      7'h24: c = 8'hAE;
      7'h25: c = 8'hAB;
      7'h26: c = 8'hA4;
      7'h27: c = 8'hA6;
      7'h28: c = 8'hED;
      7'h29: c = 8'h5D;
      7'h2C: c = 8'hEF;
      7'h2D: c = 8'hE7;
      7'h2E: c = 8'hE1;
      7'h2F: c = 8'hAC;
      7'h30: c = 8'hA8;
      7'h31: c = 8'hE2;
      7'h32: c = 8'hEC;
      7'h33: c = 8'hA1;
      7'h34: c = 8'hEE;
      7'h35: c = 8'h2E;
      default: c = common_lo(code);
    endcase
    return c;
  endfunction

  // cp866 upper case
  function automatic logic [7:0] ru_up(input logic [6:0] code);
    logic [7:0] c;
    case (code)
      7'h10: c = 8'h89;
      7'h11: c = 8'h96;
      7'h12: c = 8'h93;
      7'h13: c = 8'h8A;
      7'h14: c = 8'h85;
      7'h15: c = 8'h8D;
      7'h16: c = 8'h83;
      7'h17: c = 8'h98;
      7'h18: c = 8'h99;
      7'h19: c = 8'h87;
      7'h1A: c = 8'h95;
      7'h1B: c = 8'h9A;
      7'h1E: c = 8'h94;
      7'h1F: c = 8'h9B;
      7'h20: c = 8'h82;
      7'h21: c = 8'h80;
      7'h22: c = 8'h8F;
      7'h23: c = 8'h90;
      7'h24: c = 8'h8E;
      7'h25: c = 8'h8B;
      7'h26: c = 8'h84;
      7'h27: c = 8'h86;
      7'h28: c = 8'h9D;
      7'h29: c = 8'h7D;
      7'h2C: c = 8'h9F;
      7'h2D: c = 8'h97;
      7'h2E: c = 8'h91;
      7'h2F: c = 8'h8C;
      7'h30: c = 8'h88;
      7'h31: c = 8'h92;
      7'h32: c = 8'h9C;
      7'h33: c = 8'h81;
      7'h34: c = 8'h9E;
      7'h35: c = 8'h2C;
      default: c = common_up(code);
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/ps2_set1_scancode_translator.sv @@
// ----------------------------------------------------------------------------
// ps2_set1_scancode_translator
// Turns keyboard controller bytes (scan code set 1) into characters and
// special-key codes, tracking prefix, modifiers, caps lock and layout.
// ----------------------------------------------------------------------------
// result path: an accepted word goes through the input register, then the result register
// throughput: one word per cycle; while a result waits downstream the input
//   register still takes one word, then the input stalls
// the key state and layout counter are updated by the logic behind the input
//   register; reset clears all key state, the counter and both config registers
module ps2_set1_scancode_translator #(
  parameter int unsigned IGNORE_SLOTS = ps2s1_pkg::IGNORE_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // status_byte, data_byte, layout_value
  input  logic [0:0]                      s_axis_tuser,  // operation
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // char_code, special_key, layout_ru, layout_epoch
  output logic [47:0]                     m_axis_tdata,
  output logic [1:0]                      m_axis_tuser,  // key_kind
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ps2s1_pkg::APB_AW-1:0]    paddr,
  input  logic [ps2s1_pkg::APB_DW-1:0]    pwdata,
  output logic [ps2s1_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);

  // configuration registers
  logic [ps2s1_pkg::CODES_W-1:0] ignore_codes_q;
  logic [ps2s1_pkg::COUNT_W-1:0] ignore_count_q;
  logic                          cfg_wr;

  // input register
  logic       in_valid_q;
  logic       op_q;
  logic [7:0] status_q;
  logic [7:0] data_q;
  logic       layout_q;

  // key state
  logic        prefix_q, prefix_d;
  logic        shift_q, shift_d;
  logic        ctrl_q, ctrl_d;
  logic        caps_q, caps_d;
  logic        ru_q, ru_d;
  logic [31:0] epoch_q, epoch_d;

  // result register
  logic       out_valid_q;
  logic [1:0] kind_q, kind_d;
  logic [7:0] char_q, char_d;
  logic [4:0] spec_q, spec_d;

  logic out_free;
  logic advance;

  logic                 byte_ready;
  logic                 released;
  logic [6:0]           code;
  logic                 ignore_hit;
  logic                 up;
  logic [7:0]           c;
  ps2s1_pkg::nav_t      nav;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? {{(ps2s1_pkg::APB_DW - ps2s1_pkg::COUNT_W){1'b0}}, ignore_count_q}
                           : ignore_codes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_codes_q <= '0;
      ignore_count_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        ignore_count_q <= pwdata[ps2s1_pkg::COUNT_W-1:0];
      end else begin
        ignore_codes_q <= pwdata[ps2s1_pkg::CODES_W-1:0];
      end
    end
  end

  // handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q     <= s_axis_tuser[0];
      status_q <= s_axis_tdata[7:0];
      data_q   <= s_axis_tdata[15:8];
      layout_q <= s_axis_tdata[16];
    end
  end

  assign byte_ready = status_q[ps2s1_pkg::ST_READY_BIT] && !status_q[ps2s1_pkg::ST_MOUSE_BIT];
  assign released   = data_q[7];
  assign code       = data_q[6:0];
  assign nav        = ps2s1_pkg::nav_lookup(code);

  always_comb begin
    ignore_hit = 1'b0;
    for (int i = 0; i < IGNORE_SLOTS; i++) begin
      if ((ps2s1_pkg::COUNT_W'(i) < ignore_count_q) &&
          (ignore_codes_q[i*ps2s1_pkg::SLOT_W +: ps2s1_pkg::SLOT_W] == {1'b0, code})) begin
        ignore_hit = 1'b1;
      end
    end
  end

  // character lookup for an unprefixed make code
  always_comb begin
    up = shift_q ^ caps_q;
    if (ru_q) begin
      c = up ? ps2s1_pkg::ru_up(code) : ps2s1_pkg::ru_lo(code);
      if (c == 8'h00 && shift_q) begin
        c = ps2s1_pkg::en_up(code);
      end
      if (c == 8'h00) begin
        c = ps2s1_pkg::en_lo(code);
      end
    end else begin
      c = ps2s1_pkg::en_lo(code);
      if (c >= ps2s1_pkg::CH_LO_A && c <= ps2s1_pkg::CH_LO_Z) begin
        if (up) begin
          c = c - ps2s1_pkg::CASE_OFS;
        end
      end else if (shift_q) begin
        c = ps2s1_pkg::en_up(code);
      end
    end
    if (ctrl_q) begin
      if (c >= ps2s1_pkg::CH_LO_A && c <= ps2s1_pkg::CH_LO_Z) begin
        c = c - ps2s1_pkg::CTRL_LO;
      end else if (c >= ps2s1_pkg::CH_UP_A && c <= ps2s1_pkg::CH_UP_Z) begin
        c = c - ps2s1_pkg::CTRL_UP;
      end else if (c == ps2s1_pkg::CH_SPACE) begin
        c = 8'h00;
      end
    end
  end

  always_comb begin
    prefix_d = prefix_q;
    shift_d  = shift_q;
    ctrl_d   = ctrl_q;
    caps_d   = caps_q;
    ru_d     = ru_q;
    epoch_d  = epoch_q;
    kind_d   = ps2s1_pkg::KIND_NONE;
    char_d   = 8'h00;
    spec_d   = 5'd0;

    if (op_q == ps2s1_pkg::OP_SET_LAYOUT) begin
      if (layout_q != ru_q) begin
        ru_d    = layout_q;
        epoch_d = epoch_q + 32'd1;
      end
    end else if (!byte_ready) begin
      // dropped word, state untouched
    end else if (data_q == ps2s1_pkg::SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (!prefix_q && ignore_hit) begin
      // code on the ignore list
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if (!released) begin
        if (nav.hit) begin
          kind_d = ps2s1_pkg::KIND_SPECIAL;
          spec_d = nav.num;
        end else if (code == ps2s1_pkg::SC_E0_SLASH) begin
          kind_d = ps2s1_pkg::KIND_CHAR;
          char_d = shift_q ? ps2s1_pkg::CH_QUEST : ps2s1_pkg::CH_SLASH;
        end else if (code == ps2s1_pkg::SC_KP_SLASH) begin
          kind_d = ps2s1_pkg::KIND_CHAR;
          char_d = ps2s1_pkg::CH_SLASH;
        end
      end
    end else if (code inside {ps2s1_pkg::SC_LSHIFT, ps2s1_pkg::SC_RSHIFT}) begin
      shift_d = !released;
    end else if (code == ps2s1_pkg::SC_CTRL) begin
      ctrl_d = !released;
    end else if (code == ps2s1_pkg::SC_ALT) begin
      // alt is not tracked
    end else if (code == ps2s1_pkg::SC_CAPS) begin
      if (!released) begin
        caps_d = !caps_q;
      end
    end else if (released) begin
      // other breaks give nothing
    end else if (code inside {[ps2s1_pkg::SC_F1:ps2s1_pkg::SC_F10]}) begin
      kind_d = ps2s1_pkg::KIND_SPECIAL;
      spec_d = 5'(code - ps2s1_pkg::SC_F1);
    end else if (code inside {ps2s1_pkg::SC_LAYOUT_A, ps2s1_pkg::SC_LAYOUT_B}) begin
      ru_d    = !ru_q;
      epoch_d = epoch_q + 32'd1;
    end else if (c != 8'h00) begin
      kind_d = ps2s1_pkg::KIND_CHAR;
      char_d = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= 1'b0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      caps_q      <= 1'b0;
      ru_q        <= 1'b0;
      epoch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        prefix_q <= prefix_d;
        shift_q  <= shift_d;
        ctrl_q   <= ctrl_d;
        caps_q   <= caps_d;
        ru_q     <= ru_d;
        epoch_q  <= epoch_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= kind_d;
      char_q <= char_d;
      spec_q <= spec_d;
    end
  end

  // state only moves when a word enters the result register, so the layout
  // and counter registers always match the word on the output
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {2'b00, epoch_q, ru_q, spec_q, char_q};

endmodule
